[design/tdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants for the trial-division factorizer
// Result kinds, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int VALUE_BITS    = 32;
    localparam int FACTOR_BITS   = 31;
    localparam int MAX_RESULTS   = 30;
    localparam int CNT_BITS      = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        KIND_OUT    = 2'd0,
        KIND_PRIME  = 2'd1,
        KIND_FACTOR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT
    } t_state;

endpackage

[design/trial_division_factorizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Classifies a signed word and emits its prime factors in ascending order.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+-------------------------------
//   input    | i_value                        | start high, busy low
//   result   | o_kind, o_factor, o_last       | o_valid, one cycle, no stall
//
// A value of 1 or less gives its result in the cycle after the start; busy stays
// low. Otherwise the sequencer loads and then runs the divider once per trial
// divisor, one trial per factor plus one per divisor up to the larger of the second
// largest prime factor and the square root of the largest. Reset is synchronous
// and idles the sequencer.
// Results cannot be stalled; busy falls with the final word on the result ports.
// ----------------------------------------------------------------------------
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_BITS-1:0]  i_value,
    output logic                   o_valid,
    output logic [1:0]             o_kind,
    output logic [FACTOR_BITS-1:0] o_factor,
    output logic                   o_last
);

    t_state                 r_state, n_state;
    logic [WORD_BITS-1:0]   r_n, n_n;
    logic [WORD_BITS-1:0]   r_d, n_d;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic                   r_valid, n_valid;
    t_kind                  r_kind, n_kind;
    logic [FACTOR_BITS-1:0] r_factor, n_factor;
    logic                   r_last, n_last;

    logic [WORD_BITS+VALUE_BITS-1:0]  w_val_ext;
    logic [WORD_BITS-1:0]             w_v;
    logic                             w_out_dom;
    logic [WORD_BITS+FACTOR_BITS-1:0] w_n_ext;
    logic [WORD_BITS+FACTOR_BITS-1:0] w_d_ext;
    logic                             w_accept;
    logic                             w_div_done;
    logic [WORD_BITS-1:0]             w_quo;
    logic [WORD_BITS-1:0]             w_rem;

    assign w_val_ext = {{WORD_BITS{i_value[VALUE_BITS-1]}}, i_value};
    assign w_v       = w_val_ext[WORD_BITS-1:0];
    assign w_out_dom = w_v[WORD_BITS-1] || (w_v[WORD_BITS-1:1] == '0);
    assign w_n_ext   = {{FACTOR_BITS{1'b0}}, r_n};
    assign w_d_ext   = {{FACTOR_BITS{1'b0}}, r_d};
    assign w_accept  = start && !busy;

    tdf_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_LOAD),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_d      = r_d;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_kind   = r_kind;
        n_factor = r_factor;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_out_dom) begin
                        n_valid  = 1'b1;
                        n_kind   = KIND_OUT;
                        n_factor = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_n     = w_v;
                        n_d     = WORD_BITS'(2);
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_div_done) begin
                    if ((r_d > w_quo) ||
                        ((w_rem == '0) && (r_cnt >= CNT_BITS'(MAX_RESULTS - 1)))) begin
                        n_valid = 1'b1;
                        n_last  = 1'b1;
                        if (r_cnt == '0) begin
                            n_kind   = KIND_PRIME;
                            n_factor = '0;
                        end else begin
                            n_kind   = KIND_FACTOR;
                            n_factor = w_n_ext[FACTOR_BITS-1:0];
                        end
                        n_state = S_IDLE;
                    end else if (w_rem == '0) begin
                        n_valid  = 1'b1;
                        n_last   = 1'b0;
                        n_kind   = KIND_FACTOR;
                        n_factor = w_d_ext[FACTOR_BITS-1:0];
                        n_n      = w_quo;
                        n_cnt    = r_cnt + 1'b1;
                        n_state  = S_LOAD;
                    end else begin
                        n_d     = r_d + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_n      <= n_n;
        r_d      <= n_d;
        r_cnt    <= n_cnt;
        r_kind   <= n_kind;
        r_factor <= n_factor;
        r_last   <= n_last;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_factor = r_factor;
    assign o_last   = r_last;

    a_prime_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_FACTOR) |-> o_last && (o_factor == '0))
        else $error("prime or out-of-domain word not final or has a factor");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid && o_last)
        else $error("busy dropped without a final word");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_out_dom |=> busy)
        else $error("in-domain start did not raise busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !$past(w_accept) && $past(i_rst_n) && !$fell(busy) |-> !o_valid)
        else $error("result word while idle");

endmodule

[design/tdf_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_divider: restoring divider, one quotient bit per cycle
// Loads on i_start, runs WORD_BITS steps, pulses o_done with quotient and
// remainder held until the next start.
// ----------------------------------------------------------------------------
module tdf_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_dividend,
    input  logic [WORD_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_quotient,
    output logic [WORD_BITS-1:0] o_remainder
);

    localparam int CW = $clog2(WORD_BITS);

    logic                 r_run, n_run;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_quo, n_quo;
    logic [WORD_BITS-1:0] r_dvs, n_dvs;
    logic [WORD_BITS:0]   w_trial;
    logic [WORD_BITS:0]   w_diff;

    assign w_trial = {r_acc, r_quo[WORD_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = CW'(WORD_BITS - 1);
            n_acc = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_run) begin
            if (w_diff[WORD_BITS]) begin
                n_acc = w_trial[WORD_BITS-1:0];
                n_quo = {r_quo[WORD_BITS-2:0], 1'b0};
            end else begin
                n_acc = w_diff[WORD_BITS-1:0];
                n_quo = {r_quo[WORD_BITS-2:0], 1'b1};
            end
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_acc;

endmodule

[tb/tdf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_checker: result scoreboard for the trial-division factorizer
// Watches the command and result ports, factors every accepted value on its
// own, and compares each result word field by field against the oldest
// predicted word. Reports the failure count and the number of words still due.
// ----------------------------------------------------------------------------
module tdf_checker
    import tdf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  logic                   o_valid,
    input  logic [1:0]             o_kind,
    input  logic [FACTOR_BITS-1:0] o_factor,
    input  logic                   o_last,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        t_kind                  kind;
        logic [FACTOR_BITS-1:0] factor;
        logic                   last;
    } t_factor_word;

    t_factor_word factor_queue[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void push_factor_word(input t_kind kind, input longint unsigned factor,
                                             input logic last);
        t_factor_word w;
        w.kind   = kind;
        w.factor = factor[FACTOR_BITS-1:0];
        w.last   = last;
        factor_queue.push_back(w);
    endfunction

    function automatic void predict_factors(input logic [VALUE_BITS-1:0] value);
        longint unsigned remain;
        longint unsigned divisor;
        int              count;
        logic            capped;
        remain  = value;
        divisor = 2;
        count   = 0;
        capped  = 1'b0;
        if (value[VALUE_BITS-1] || remain <= 1) begin
            push_factor_word(KIND_OUT, 0, 1'b1);
            return;
        end
        while (!capped && divisor <= remain / divisor) begin
            if (remain % divisor == 0) begin
                // hand the whole cofactor over as the last word once the cap is hit
                if (count >= MAX_RESULTS - 1) begin
                    capped = 1'b1;
                end else begin
                    push_factor_word(KIND_FACTOR, divisor, 1'b0);
                    count++;
                    remain = remain / divisor;
                end
            end else begin
                divisor++;
            end
        end
        if (count == 0)
            push_factor_word(KIND_PRIME, 0, 1'b1);
        else
            push_factor_word(KIND_FACTOR, remain, 1'b1);
    endfunction

    always @(posedge i_clk) begin : check_words
        t_factor_word want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (factor_queue.size() == 0) begin
                    $error("unexpected result word: kind %0d factor %0d last %0d",
                           o_kind, o_factor, o_last);
                    fail_count++;
                end else begin
                    want = factor_queue.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, o_kind);
                        fail_count++;
                    end
                    if (o_factor !== want.factor) begin
                        $error("factor mismatch: expected %0d, actual %0d",
                               want.factor, o_factor);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_factors(i_value);
            pending = factor_queue.size();
        end
    end

endmodule

[tb/trial_division_factorizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_tb: top-level testbench for the factorizer
// Drives directed edge values, then random values weighted toward cheap
// factorizations, with random idle gaps; a side checker scores every result
// word and a no-progress watchdog bounds the run.
// ----------------------------------------------------------------------------
module trial_division_factorizer_tb;
    import tdf_pkg::*;

    localparam int RANDOM_WORDS = 100;
    localparam int IDLE_LIMIT   = 200_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int EDGE_COUNT   = 18;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [VALUE_BITS-1:0]  i_value;
    logic                   o_valid;
    logic [1:0]             o_kind;
    logic [FACTOR_BITS-1:0] o_factor;
    logic                   o_last;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;

    logic [VALUE_BITS-1:0] edge_values [EDGE_COUNT] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd2, 32'd3, 32'd4, 32'd6,
        32'd9, 32'd25, 32'd97, 32'd65521, 32'd65536, 32'h4000_0000, 32'h7FFF_FFFE,
        32'd223092870, 32'd999999, 32'h0000_FFFF
    };

    always #10 i_clk = ~i_clk;

    trial_division_factorizer #(
        .WORD_BITS(WORD_BITS_DEF)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_kind   (o_kind),
        .o_factor (o_factor),
        .o_last   (o_last)
    );

    tdf_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_kind     (o_kind),
        .o_factor   (o_factor),
        .o_last     (o_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [VALUE_BITS-1:0] value);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        hold_off(1);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        else if (r < 17)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 200);
    endfunction

    // keep the largest cofactor small so that trial division stays short
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int              sel;
        int              count;
        longint unsigned prod;
        longint unsigned f;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            case ($urandom_range(0, 2))
                0:       return $urandom | 32'h8000_0000;
                1:       return $urandom_range(0, 1);
                default: return ~32'($urandom_range(0, 99));
            endcase
        end else if (sel < 7) begin
            prod  = 1;
            count = $urandom_range(1, 30);
            repeat (count) begin
                f = $urandom_range(0, 1) ? $urandom_range(2, 7) : $urandom_range(2, 47);
                if (prod * f <= 64'h7FFF_FFFF)
                    prod = prod * f;
            end
            return prod[VALUE_BITS-1:0];
        end else begin
            return $urandom_range(2, ($urandom_range(0, 3) == 0) ? 65535 : 1023);
        end
    endfunction

    initial begin
        start   = 1'b0;
        i_value = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < EDGE_COUNT; i++) begin
            send_word(edge_values[i]);
            hold_off(pick_gap());
        end
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2)
                drain_results();
            send_word(pick_value());
            // run back to back through one stretch
            if (i < 20 || i >= 40)
                hold_off(pick_gap());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
